[hw/rtl/csl_pkg.sv]
// Shared types, codes and character-class functions for the C subset lexer.
// Used by csl_front, csl_queue, csl_back and c_subset_lexer_top.
`timescale 1ns / 1ps

package csl_pkg;

    localparam int KEYWORD_CHARS = 8;
    localparam int LENGTH_BITS   = 12;
    localparam int OFFSET_BITS   = 32;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    localparam logic [3:0] K_ID   = 4'd0;
    localparam logic [3:0] K_KW   = 4'd1;
    localparam logic [3:0] K_OP   = 4'd2;
    localparam logic [3:0] K_SEP  = 4'd3;
    localparam logic [3:0] K_INT  = 4'd4;
    localparam logic [3:0] K_CHAR = 4'd5;
    localparam logic [3:0] K_STR  = 4'd6;
    localparam logic [3:0] K_ERR  = 4'd7;
    localparam logic [3:0] K_END  = 4'd8;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_STRAY  = 3'd1;
    localparam logic [2:0] E_OCTAL  = 3'd2;
    localparam logic [2:0] E_ESCAPE = 3'd3;
    localparam logic [2:0] E_UNTERM = 3'd4;

    localparam logic [5:0] OP_LS    = 6'd24;
    localparam logic [5:0] OP_RS    = 6'd25;
    localparam logic [5:0] OP_LS_EQ = 6'd32;
    localparam logic [5:0] OP_RS_EQ = 6'd33;

    typedef enum logic [12:0] {
        M_IDLE     = 13'h0001,
        M_IDENT    = 13'h0002,
        M_NUMBER   = 13'h0004,
        M_OP1      = 13'h0008,
        M_SHIFT    = 13'h0010,
        M_COMMENT  = 13'h0020,
        M_COMSTAR  = 13'h0040,
        M_STRING   = 13'h0080,
        M_CHOPEN   = 13'h0100,
        M_CHONE    = 13'h0200,
        M_ESC      = 13'h0400,
        M_ESCQ     = 13'h0800,
        M_ESCCLOSE = 13'h1000
    } mode_t;

    // One token descriptor as it travels from the front to the back.
    typedef struct packed {
        logic [3:0]             kind;
        logic [5:0]             code;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic [2:0]             err;
    } token_t;

    // Everything one input item produced: up to two tokens.
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } entry_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    // Returns {found, index}.
    function automatic logic [5:0] single_op(input logic [7:0] b);
        logic [5:0] r;
        r = 6'h00;
        case (b)
            "<": r = {1'b1, 5'd0};
            ">": r = {1'b1, 5'd1};
            "=": r = {1'b1, 5'd2};
            "!": r = {1'b1, 5'd3};
            "%": r = {1'b1, 5'd4};
            "^": r = {1'b1, 5'd5};
            "&": r = {1'b1, 5'd6};
            "*": r = {1'b1, 5'd7};
            "-": r = {1'b1, 5'd8};
            "+": r = {1'b1, 5'd9};
            "~": r = {1'b1, 5'd10};
            "|": r = {1'b1, 5'd11};
            "/": r = {1'b1, 5'd12};
            "?": r = {1'b1, 5'd13};
            default: r = 6'h00;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] separator(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h00;
        case (b)
            "(": r = {1'b1, 4'd0};
            ")": r = {1'b1, 4'd1};
            "[": r = {1'b1, 4'd2};
            "]": r = {1'b1, 4'd3};
            "{": r = {1'b1, 4'd4};
            "}": r = {1'b1, 4'd5};
            ",": r = {1'b1, 4'd6};
            ":": r = {1'b1, 4'd7};
            ";": r = {1'b1, 4'd8};
            default: r = 5'h00;
        endcase
        return r;
    endfunction

    // Returns {found, code} for a two-character operator.
    function automatic logic [6:0] pair_op(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] r;
        r = 7'h00;
        if (b == "=")
        begin
            case (a)
                "+": r = {1'b1, 6'd14};
                "-": r = {1'b1, 6'd15};
                "*": r = {1'b1, 6'd16};
                "/": r = {1'b1, 6'd17};
                "%": r = {1'b1, 6'd18};
                "&": r = {1'b1, 6'd19};
                "^": r = {1'b1, 6'd20};
                "|": r = {1'b1, 6'd21};
                "<": r = {1'b1, 6'd26};
                ">": r = {1'b1, 6'd27};
                "=": r = {1'b1, 6'd28};
                "!": r = {1'b1, 6'd29};
                default: r = 7'h00;
            endcase
        end
        else if (a == b)
        begin
            case (a)
                "+": r = {1'b1, 6'd22};
                "-": r = {1'b1, 6'd23};
                "<": r = {1'b1, OP_LS};
                ">": r = {1'b1, OP_RS};
                "&": r = {1'b1, 6'd30};
                "|": r = {1'b1, 6'd31};
                default: r = 7'h00;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_esc_letter(input logic [7:0] b);
        return b == "n" || b == 8'h27 || b == 8'h22 || b == 8'h5c || b == "a" ||
               b == "b" || b == "f" || b == "t" || b == "r" || b == "v" || b == "?";
    endfunction

    // Returns {found, keyword index} for an identifier of the given length.
    function automatic logic [4:0] keyword(input logic [8*KEYWORD_CHARS-1:0] buf_in,
                                           input logic [LENGTH_BITS-1:0] len);
        logic [4:0] r;
        logic [63:0] w;
        w = buf_in[63:0];
        r = 5'h00;
        case (len)
            12'd2:
            begin
                if (w[15:0] == {"o", "d"}) r = {1'b1, 4'd0};
                if (w[15:0] == {"f", "i"}) r = {1'b1, 4'd11};
            end
            12'd3:
            begin
                if (w[23:0] == {"r", "o", "f"}) r = {1'b1, 4'd1};
                if (w[23:0] == {"t", "n", "i"}) r = {1'b1, 4'd12};
            end
            12'd4:
            begin
                if (w[31:0] == {"e", "s", "l", "e"}) r = {1'b1, 4'd5};
                if (w[31:0] == {"o", "t", "o", "g"}) r = {1'b1, 4'd6};
                if (w[31:0] == {"d", "i", "o", "v"}) r = {1'b1, 4'd9};
                if (w[31:0] == {"r", "a", "h", "c"}) r = {1'b1, 4'd10};
                if (w[31:0] == {"g", "n", "o", "l"}) r = {1'b1, 4'd14};
            end
            12'd5:
            begin
                if (w[39:0] == {"k", "a", "e", "r", "b"}) r = {1'b1, 4'd3};
                if (w[39:0] == {"t", "r", "o", "h", "s"}) r = {1'b1, 4'd4};
                if (w[39:0] == {"e", "l", "i", "h", "w"}) r = {1'b1, 4'd15};
            end
            12'd6:
            begin
                if (w[47:0] == {"n", "r", "u", "t", "e", "r"}) r = {1'b1, 4'd2};
                if (w[47:0] == {"d", "e", "n", "g", "i", "s"}) r = {1'b1, 4'd7};
            end
            12'd8:
            begin
                if (w == {"d", "e", "n", "g", "i", "s", "n", "u"}) r = {1'b1, 4'd8};
                if (w == {"e", "u", "n", "i", "t", "n", "o", "c"}) r = {1'b1, 4'd13};
            end
            default: r = 5'h00;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/csl_front.sv]
// Front end of the lexer: scan state machine that turns one byte per item into
// up to two token descriptors. Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        char_code,
    input  logic              end_of_stream,
    output logic              produce,
    output csl_pkg::entry_t   entry
);

    csl_pkg::mode_t mode_reg, mode_next;
    logic [7:0] pend_op_reg, pend_op_next;
    logic [8*csl_pkg::KEYWORD_CHARS-1:0] kw_reg, kw_next;
    logic [csl_pkg::OFFSET_BITS-1:0] cur_reg, cur_next, start_reg, start_next;
    logic [csl_pkg::LENGTH_BITS-1:0] len_reg, len_next, len_inc;
    logic prev_bs_reg, prev_bs_next;
    logic [1:0] dig_reg, dig_next;
    logic [2:0] perr_reg, perr_next;

    function automatic csl_pkg::token_t tok(input logic [3:0] k, input logic [5:0] c,
            input logic [csl_pkg::OFFSET_BITS-1:0] s, input logic [csl_pkg::LENGTH_BITS-1:0] l,
            input logic [2:0] e);
        csl_pkg::token_t t;
        t.kind = k;
        t.code = c;
        t.start = s;
        t.length = l;
        t.err = e;
        return t;
    endfunction

    always_comb
    begin
        logic relex;
        logic [1:0] n;
        logic [4:0] kw;
        logic [6:0] pc;
        logic [5:0] so;
        logic [4:0] sp;
        csl_pkg::token_t t0, t1, tn;
        logic [7:0] b;

        b = char_code;
        mode_next = mode_reg;
        pend_op_next = pend_op_reg;
        kw_next = kw_reg;
        cur_next = cur_reg;
        start_next = start_reg;
        len_next = len_reg;
        prev_bs_next = prev_bs_reg;
        dig_next = dig_reg;
        perr_next = perr_reg;
        len_inc = (len_reg == csl_pkg::LEN_MAX) ? len_reg : len_reg + 1'b1;
        relex = 1'b0;
        n = 2'd0;
        tn = tok(csl_pkg::K_ID, 6'd0, start_reg, len_reg, csl_pkg::E_NONE);
        t0 = tn;
        t1 = tn;
        kw = csl_pkg::keyword(kw_reg, len_reg);
        pc = csl_pkg::pair_op(pend_op_reg, b);
        so = csl_pkg::single_op(pend_op_reg);
        sp = csl_pkg::separator(b);

        if (end_of_stream)
        begin
            n = 2'd1;
            unique case (mode_reg)
                csl_pkg::M_IDENT: tn = kw[4] ?
                    tok(csl_pkg::K_KW, {2'b00, kw[3:0]}, start_reg, len_reg, csl_pkg::E_NONE) :
                    tok(csl_pkg::K_ID, 6'd0, start_reg, len_reg, csl_pkg::E_NONE);
                csl_pkg::M_NUMBER:
                    tn = tok(csl_pkg::K_INT, 6'd0, start_reg, len_reg, csl_pkg::E_NONE);
                csl_pkg::M_OP1:
                    tn = tok(csl_pkg::K_OP, {1'b0, so[4:0]}, start_reg, len_reg,
                             csl_pkg::E_NONE);
                csl_pkg::M_SHIFT:
                    tn = tok(csl_pkg::K_OP, pend_op_reg == "<" ? csl_pkg::OP_LS :
                             csl_pkg::OP_RS, start_reg, len_reg, csl_pkg::E_NONE);
                csl_pkg::M_STRING, csl_pkg::M_CHOPEN, csl_pkg::M_CHONE, csl_pkg::M_ESC,
                csl_pkg::M_ESCQ, csl_pkg::M_ESCCLOSE:
                    tn = tok(csl_pkg::K_ERR, 6'd0, start_reg, len_reg, csl_pkg::E_UNTERM);
                default: n = 2'd0;
            endcase
            if (n == 2'd1)
            begin
                t0 = tn;
                t1 = tok(csl_pkg::K_END, 6'd0, cur_reg, '0, csl_pkg::E_NONE);
                n = 2'd2;
            end
            else
            begin
                t0 = tok(csl_pkg::K_END, 6'd0, cur_reg, '0, csl_pkg::E_NONE);
                n = 2'd1;
            end
            mode_next = csl_pkg::M_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                csl_pkg::M_IDLE: relex = 1'b1;
                csl_pkg::M_IDENT:
                    if (csl_pkg::is_alpha(b) || csl_pkg::is_digit(b))
                    begin
                        for (int i = 1; i < csl_pkg::KEYWORD_CHARS; i++)
                            if (len_reg == i[csl_pkg::LENGTH_BITS-1:0])
                                kw_next[8*i +: 8] = b;
                        len_next = len_inc;
                    end
                    else
                    begin
                        n = 2'd1;
                        t0 = kw[4] ?
                            tok(csl_pkg::K_KW, {2'b00, kw[3:0]}, start_reg, len_reg,
                                csl_pkg::E_NONE) :
                            tok(csl_pkg::K_ID, 6'd0, start_reg, len_reg, csl_pkg::E_NONE);
                        relex = 1'b1;
                    end
                csl_pkg::M_NUMBER:
                    if (csl_pkg::is_digit(b)) len_next = len_inc;
                    else
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_INT, 6'd0, start_reg, len_reg, csl_pkg::E_NONE);
                        relex = 1'b1;
                    end
                csl_pkg::M_OP1:
                    if (pend_op_reg == "/" && b == "*") mode_next = csl_pkg::M_COMMENT;
                    else if (pc[6] && (pc[5:0] == csl_pkg::OP_LS || pc[5:0] == csl_pkg::OP_RS))
                    begin
                        mode_next = csl_pkg::M_SHIFT;
                        len_next = len_inc;
                    end
                    else if (pc[6])
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_OP, pc[5:0], start_reg, len_inc, csl_pkg::E_NONE);
                        mode_next = csl_pkg::M_IDLE;
                    end
                    else
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_OP, {1'b0, so[4:0]}, start_reg, len_reg,
                                 csl_pkg::E_NONE);
                        relex = 1'b1;
                    end
                csl_pkg::M_SHIFT:
                    if (b == "=")
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_OP, pend_op_reg == "<" ? csl_pkg::OP_LS_EQ :
                                 csl_pkg::OP_RS_EQ, start_reg, len_inc, csl_pkg::E_NONE);
                        mode_next = csl_pkg::M_IDLE;
                    end
                    else
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_OP, pend_op_reg == "<" ? csl_pkg::OP_LS :
                                 csl_pkg::OP_RS, start_reg, len_reg, csl_pkg::E_NONE);
                        relex = 1'b1;
                    end
                csl_pkg::M_COMMENT:
                    if (b == "*") mode_next = csl_pkg::M_COMSTAR;
                csl_pkg::M_COMSTAR:
                    if (b == "/") mode_next = csl_pkg::M_IDLE;
                    else if (b != "*") mode_next = csl_pkg::M_COMMENT;
                csl_pkg::M_STRING:
                begin
                    len_next = len_inc;
                    if (b == 8'h22 && !prev_bs_reg)
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_STR, 6'd0, start_reg, len_inc, csl_pkg::E_NONE);
                        mode_next = csl_pkg::M_IDLE;
                    end
                    else prev_bs_next = (b == 8'h5c);
                end
                csl_pkg::M_CHOPEN:
                begin
                    len_next = len_inc;
                    if (b == 8'h5c)
                    begin
                        mode_next = csl_pkg::M_ESC;
                        dig_next = 2'd0;
                        perr_next = csl_pkg::E_NONE;
                    end
                    else mode_next = csl_pkg::M_CHONE;
                end
                csl_pkg::M_CHONE, csl_pkg::M_ESCQ:
                    if (b == 8'h27)
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_CHAR, 6'd0, start_reg, len_inc, csl_pkg::E_NONE);
                        mode_next = csl_pkg::M_IDLE;
                    end
                    else
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_ERR, 6'd0, start_reg, len_reg, csl_pkg::E_STRAY);
                        relex = 1'b1;
                    end
                csl_pkg::M_ESC:
                    if (b == 8'h27)
                    begin
                        len_next = len_inc;
                        if (dig_reg == 2'd0) mode_next = csl_pkg::M_ESCQ;
                        else
                        begin
                            n = 2'd1;
                            t0 = (perr_reg != csl_pkg::E_NONE) ?
                                tok(csl_pkg::K_ERR, 6'd0, start_reg, len_inc, perr_reg) :
                                tok(csl_pkg::K_CHAR, 6'd0, start_reg, len_inc, csl_pkg::E_NONE);
                            mode_next = csl_pkg::M_IDLE;
                        end
                    end
                    else
                    begin
                        len_next = len_inc;
                        if (csl_pkg::is_digit(b))
                        begin
                            dig_next = dig_reg + 2'd1;
                            if (b > "7") perr_next = csl_pkg::E_OCTAL;
                            if (dig_reg == 2'd2) mode_next = csl_pkg::M_ESCCLOSE;
                        end
                        else
                        begin
                            if (!csl_pkg::is_esc_letter(b)) perr_next = csl_pkg::E_ESCAPE;
                            mode_next = csl_pkg::M_ESCCLOSE;
                        end
                    end
                csl_pkg::M_ESCCLOSE:
                    if (b == 8'h27)
                    begin
                        n = 2'd1;
                        len_next = len_inc;
                        t0 = (perr_reg != csl_pkg::E_NONE) ?
                            tok(csl_pkg::K_ERR, 6'd0, start_reg, len_inc, perr_reg) :
                            tok(csl_pkg::K_CHAR, 6'd0, start_reg, len_inc, csl_pkg::E_NONE);
                        mode_next = csl_pkg::M_IDLE;
                    end
                    else
                    begin
                        n = 2'd1;
                        t0 = tok(csl_pkg::K_ERR, 6'd0, start_reg, len_reg, csl_pkg::E_STRAY);
                        relex = 1'b1;
                    end
                default: relex = 1'b1;
            endcase

            if (relex)
            begin
                start_next = cur_reg;
                len_next = {{(csl_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
                mode_next = csl_pkg::M_IDLE;
                if (csl_pkg::is_space(b))
                begin
                end
                else if (sp[4])
                begin
                    tn = tok(csl_pkg::K_SEP, {2'b00, sp[3:0]}, cur_reg,
                             {{(csl_pkg::LENGTH_BITS-1){1'b0}}, 1'b1}, csl_pkg::E_NONE);
                    if (n == 2'd0) t0 = tn;
                    else t1 = tn;
                    n = n + 2'd1;
                end
                else if (b == 8'h22)
                begin
                    mode_next = csl_pkg::M_STRING;
                    prev_bs_next = 1'b0;
                end
                else if (b == 8'h27) mode_next = csl_pkg::M_CHOPEN;
                else if (csl_pkg::is_digit(b)) mode_next = csl_pkg::M_NUMBER;
                else if (csl_pkg::single_op(b) != 6'h00)
                begin
                    mode_next = csl_pkg::M_OP1;
                    pend_op_next = b;
                end
                else if (csl_pkg::is_alpha(b))
                begin
                    mode_next = csl_pkg::M_IDENT;
                    kw_next[7:0] = b;
                end
            end
            cur_next = cur_reg + 1'b1;
        end

        produce = (n != 2'd0);
        entry.two = (n == 2'd2);
        entry.first = t0;
        entry.second = t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csl_pkg::M_IDLE;
            pend_op_reg <= '0;
            cur_reg <= '0;
            start_reg <= '0;
            len_reg <= '0;
            prev_bs_reg <= 1'b0;
            dig_reg <= '0;
            perr_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            pend_op_reg <= pend_op_next;
            cur_reg <= cur_next;
            start_reg <= start_next;
            len_reg <= len_next;
            prev_bs_reg <= prev_bs_next;
            dig_reg <= dig_next;
            perr_reg <= perr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) kw_reg <= kw_next;
    end

endmodule

[hw/rtl/csl_queue.sv]
// Two-entry queue of per-item token groups between front and back.
// Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csl_pkg::entry_t push_data,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output csl_pkg::entry_t head
);

    csl_pkg::entry_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign not_empty = (cnt_reg != 2'd0);
    assign full = (cnt_reg == 2'd2);
    assign head = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

endmodule

[hw/rtl/csl_back.sv]
// Back end of the lexer: serializes each token group onto the output channel
// and marks the last token of every item. Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  csl_pkg::entry_t head,
    output logic            pop,
    output logic            valid,
    input  logic            stall,
    output csl_pkg::token_t tok,
    output logic            last
);

    logic second_reg;

    assign valid = avail;
    assign tok = second_reg ? head.second : head.first;
    assign last = second_reg || !head.two;
    assign pop = avail && !stall && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) second_reg <= 1'b0;
        else if (avail && !stall) second_reg <= !last;
    end

endmodule

[hw/rtl/c_subset_lexer_top.sv]
// C subset lexer: one source byte or end mark per input item, token descriptors out.
// Usage:
//   Input channel (in_valid/in_stall) carries char_code and end_of_stream. Each
//   accepted item gives zero, one or two tokens on the output channel
//   (out_valid/out_stall); last_of_run marks the final token of an item.
//   Classification happens in the same cycle the byte is accepted; its tokens
//   sit in a two-entry queue and reach the outputs in the next cycle at the
//   earliest, after any tokens queued ahead of them.
//   Throughput is one byte per cycle while the queue is not full; an item with
//   two tokens holds the output for both in turn, which the queue absorbs until it fills.
//   in_stall rises only when the queue is full. When the receiver stalls the
//   current token holds steady and the queue fills, then input stalls.
//   Reset clears the scan state, offsets and queue; the lexer starts idle at
//   offset zero. The end-of-stream item flushes any open token, emits the end
//   token, and does not advance the offset.
// Depends on csl_pkg, csl_front, csl_queue, csl_back.
`timescale 1ns / 1ps

module c_subset_lexer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [5:0]  token_code,
    output logic [31:0] token_start,
    output logic [11:0] token_length,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    logic take, produce, full, not_empty, pop;
    csl_pkg::entry_t entry, head;
    csl_pkg::token_t tok;

    assign in_stall = full;
    assign take = in_valid && !full;

    csl_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .char_code(char_code),
        .end_of_stream(end_of_stream), .produce(produce), .entry(entry)
    );

    csl_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take && produce), .push_data(entry),
        .pop(pop), .not_empty(not_empty), .full(full), .head(head)
    );

    csl_back u_back (
        .clk(clk), .rst_n(rst_n), .avail(not_empty), .head(head), .pop(pop),
        .valid(out_valid), .stall(out_stall), .tok(tok), .last(last_of_run)
    );

    assign token_kind = tok.kind;
    assign token_code = tok.code;
    assign token_start = tok.start;
    assign token_length = tok.length;
    assign error_code = tok.err;

endmodule

[verif/csl_checker.sv]
// Token checker for the C subset lexer: watches both channels, predicts tokens.
// Depends on csl_pkg for token kinds, error codes, operator codes and scan modes.
`timescale 1ns / 1ps

module csl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_stream,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  token_kind,
    input  logic [5:0]  token_code,
    input  logic [31:0] token_start,
    input  logic [11:0] token_length,
    input  logic [2:0]  error_code,
    input  logic        last_of_run,
    output int          fail_count,
    output int          tokens_due_count
);

    typedef struct {
        logic [3:0]  kind;
        logic [5:0]  code;
        logic [31:0] start;
        logic [11:0] length;
        logic [2:0]  err;
        logic        last;
    } tok_t;

    tok_t tokens_due[$];

    localparam string SEP_CHARS = "()[]{},:;";
    localparam string OP_CHARS  = "<>=!%^&*-+~|/?";
    localparam string PAIR_A    = "+-*/%&^|+-<><>=!&|";
    localparam string PAIR_B    = "========+-<>====&|";
    localparam string ESC_CHARS = "n'\"\\abftrv?";
    string kw_words[16] = '{"do", "for", "return", "break", "short", "else", "goto",
        "signed", "unsigned", "void", "char", "if", "int", "continue", "long", "while"};

    csl_pkg::mode_t mode;
    logic [7:0]  op_char;
    logic [7:0]  word_buf[csl_pkg::KEYWORD_CHARS];
    logic [31:0] cur_off;
    logic [31:0] tok_off;
    logic [11:0] run_len;
    logic        after_bslash;
    logic [1:0]  esc_digits;
    logic [2:0]  esc_err;

    assign tokens_due_count = tokens_due.size();

    function automatic int find_in(string t, logic [7:0] b);
        for (int i = 0; i < t.len(); i++)
            if (t[i] == b) return i;
        return -1;
    endfunction

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [11:0] sat_inc(logic [11:0] v);
        return (v == csl_pkg::LEN_MAX) ? v : v + 12'd1;
    endfunction

    task automatic add_tok(input logic [3:0] k, input logic [5:0] c, input logic [31:0] s,
                           input logic [11:0] l, input logic [2:0] e);
        tok_t t;
        t = '{k, c, s, l, e, 1'b0};
        tokens_due.push_back(t);
    endtask

    task automatic word_token();
        logic same;
        for (int k = 0; k < 16; k++)
        begin
            if (run_len == kw_words[k].len() && kw_words[k].len() <= csl_pkg::KEYWORD_CHARS)
            begin
                same = 1'b1;
                for (int j = 0; j < kw_words[k].len(); j++)
                    if (word_buf[j] != kw_words[k][j]) same = 1'b0;
                if (same)
                begin
                    add_tok(csl_pkg::K_KW, 6'(k), tok_off, run_len, csl_pkg::E_NONE);
                    return;
                end
            end
        end
        add_tok(csl_pkg::K_ID, 6'd0, tok_off, run_len, csl_pkg::E_NONE);
    endtask

    task automatic single_token();
        int c;
        c = find_in(OP_CHARS, op_char);
        add_tok(csl_pkg::K_OP, (c < 0) ? 6'd0 : 6'(c), tok_off, run_len, csl_pkg::E_NONE);
    endtask

    task automatic close_char();
        run_len = sat_inc(run_len);
        if (esc_err != csl_pkg::E_NONE)
            add_tok(csl_pkg::K_ERR, 6'd0, tok_off, run_len, esc_err);
        else add_tok(csl_pkg::K_CHAR, 6'd0, tok_off, run_len, csl_pkg::E_NONE);
        mode = csl_pkg::M_IDLE;
    endtask

    task automatic start_token(input logic [7:0] b);
        int s;
        s = find_in(SEP_CHARS, b);
        tok_off = cur_off;
        run_len = 12'd1;
        mode = csl_pkg::M_IDLE;
        if (is_blank(b)) return;
        if (s >= 0) add_tok(csl_pkg::K_SEP, 6'(s), tok_off, 12'd1, csl_pkg::E_NONE);
        else if (b == "\"")
        begin
            mode = csl_pkg::M_STRING;
            after_bslash = 1'b0;
        end
        else if (b == "'") mode = csl_pkg::M_CHOPEN;
        else if (is_num(b)) mode = csl_pkg::M_NUMBER;
        else if (find_in(OP_CHARS, b) >= 0)
        begin
            mode = csl_pkg::M_OP1;
            op_char = b;
        end
        else if (is_letter(b))
        begin
            mode = csl_pkg::M_IDENT;
            word_buf[0] = b;
        end
    endtask

    // redo is set when no token is open or the byte ends the open token without belonging to it.
    task automatic continue_token(input logic [7:0] b, output logic redo);
        int c;
        redo = 1'b0;
        case (mode)
            csl_pkg::M_IDENT:
                if (is_letter(b) || is_num(b))
                begin
                    if (run_len < csl_pkg::KEYWORD_CHARS) word_buf[run_len[2:0]] = b;
                    run_len = sat_inc(run_len);
                end
                else
                begin
                    word_token();
                    redo = 1'b1;
                end
            csl_pkg::M_NUMBER:
                if (is_num(b)) run_len = sat_inc(run_len);
                else
                begin
                    add_tok(csl_pkg::K_INT, 6'd0, tok_off, run_len, csl_pkg::E_NONE);
                    redo = 1'b1;
                end
            csl_pkg::M_OP1:
            begin
                c = -1;
                for (int i = 0; i < 18; i++)
                    if (PAIR_A[i] == op_char && PAIR_B[i] == b) c = 14 + i;
                if (op_char == "/" && b == "*") mode = csl_pkg::M_COMMENT;
                else if (c == csl_pkg::OP_LS || c == csl_pkg::OP_RS)
                begin
                    mode = csl_pkg::M_SHIFT;
                    run_len = sat_inc(run_len);
                end
                else if (c >= 0)
                begin
                    add_tok(csl_pkg::K_OP, 6'(c), tok_off, sat_inc(run_len), csl_pkg::E_NONE);
                    mode = csl_pkg::M_IDLE;
                end
                else
                begin
                    single_token();
                    redo = 1'b1;
                end
            end
            csl_pkg::M_SHIFT:
                if (b == "=")
                begin
                    add_tok(csl_pkg::K_OP, (op_char == "<") ? csl_pkg::OP_LS_EQ :
                            csl_pkg::OP_RS_EQ, tok_off, sat_inc(run_len), csl_pkg::E_NONE);
                    mode = csl_pkg::M_IDLE;
                end
                else
                begin
                    add_tok(csl_pkg::K_OP, (op_char == "<") ? csl_pkg::OP_LS : csl_pkg::OP_RS,
                            tok_off, run_len, csl_pkg::E_NONE);
                    redo = 1'b1;
                end
            csl_pkg::M_COMMENT:
                if (b == "*") mode = csl_pkg::M_COMSTAR;
            csl_pkg::M_COMSTAR:
                if (b == "/") mode = csl_pkg::M_IDLE;
                else if (b != "*") mode = csl_pkg::M_COMMENT;
            csl_pkg::M_STRING:
            begin
                run_len = sat_inc(run_len);
                if (b == "\"" && !after_bslash)
                begin
                    add_tok(csl_pkg::K_STR, 6'd0, tok_off, run_len, csl_pkg::E_NONE);
                    mode = csl_pkg::M_IDLE;
                end
                else after_bslash = (b == "\\");
            end
            csl_pkg::M_CHOPEN:
            begin
                run_len = sat_inc(run_len);
                if (b == "\\")
                begin
                    mode = csl_pkg::M_ESC;
                    esc_digits = 2'd0;
                    esc_err = csl_pkg::E_NONE;
                end
                else mode = csl_pkg::M_CHONE;
            end
            csl_pkg::M_CHONE, csl_pkg::M_ESCQ:
                if (b == "'")
                begin
                    add_tok(csl_pkg::K_CHAR, 6'd0, tok_off, sat_inc(run_len), csl_pkg::E_NONE);
                    mode = csl_pkg::M_IDLE;
                end
                else
                begin
                    add_tok(csl_pkg::K_ERR, 6'd0, tok_off, run_len, csl_pkg::E_STRAY);
                    redo = 1'b1;
                end
            csl_pkg::M_ESC:
                if (b == "'")
                begin
                    if (esc_digits == 2'd0)
                    begin
                        mode = csl_pkg::M_ESCQ;
                        run_len = sat_inc(run_len);
                    end
                    else close_char();
                end
                else
                begin
                    run_len = sat_inc(run_len);
                    if (is_num(b))
                    begin
                        esc_digits = esc_digits + 2'd1;
                        if (b > "7") esc_err = csl_pkg::E_OCTAL;
                        if (esc_digits == 2'd3) mode = csl_pkg::M_ESCCLOSE;
                    end
                    else
                    begin
                        if (find_in(ESC_CHARS, b) < 0) esc_err = csl_pkg::E_ESCAPE;
                        mode = csl_pkg::M_ESCCLOSE;
                    end
                end
            csl_pkg::M_ESCCLOSE:
                if (b == "'") close_char();
                else
                begin
                    add_tok(csl_pkg::K_ERR, 6'd0, tok_off, run_len, csl_pkg::E_STRAY);
                    redo = 1'b1;
                end
            default: redo = 1'b1;
        endcase
    endtask

    task automatic lex_item(input logic [7:0] b, input logic eos);
        int before_n;
        logic redo;
        before_n = tokens_due.size();
        if (eos)
        begin
            case (mode)
                csl_pkg::M_IDENT: word_token();
                csl_pkg::M_NUMBER:
                    add_tok(csl_pkg::K_INT, 6'd0, tok_off, run_len, csl_pkg::E_NONE);
                csl_pkg::M_OP1: single_token();
                csl_pkg::M_SHIFT:
                    add_tok(csl_pkg::K_OP, (op_char == "<") ? csl_pkg::OP_LS : csl_pkg::OP_RS,
                            tok_off, run_len, csl_pkg::E_NONE);
                csl_pkg::M_STRING, csl_pkg::M_CHOPEN, csl_pkg::M_CHONE, csl_pkg::M_ESC,
                csl_pkg::M_ESCQ, csl_pkg::M_ESCCLOSE:
                    add_tok(csl_pkg::K_ERR, 6'd0, tok_off, run_len, csl_pkg::E_UNTERM);
                default: ;
            endcase
            add_tok(csl_pkg::K_END, 6'd0, cur_off, 12'd0, csl_pkg::E_NONE);
            mode = csl_pkg::M_IDLE;
        end
        else
        begin
            continue_token(b, redo);
            if (redo) start_token(b);
            cur_off = cur_off + 32'd1;
        end
        if (tokens_due.size() > before_n) tokens_due[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tok_t t;
        if (!rst_n)
        begin
            mode = csl_pkg::M_IDLE;
            op_char = 8'd0;
            cur_off = 32'd0;
            tok_off = 32'd0;
            run_len = 12'd0;
            after_bslash = 1'b0;
            esc_digits = 2'd0;
            esc_err = csl_pkg::E_NONE;
            tokens_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tokens_due.size() == 0)
                begin
                    fail_count++;
                    $display("%t: token with none expected: kind %0d code %0d start %0d len %0d",
                             $time, token_kind, token_code, token_start, token_length);
                end
                else
                begin
                    t = tokens_due.pop_front();
                    if (token_kind !== t.kind || token_code !== t.code ||
                        token_start !== t.start || token_length !== t.length ||
                        error_code !== t.err || last_of_run !== t.last)
                    begin
                        fail_count++;
                        $display("%t: mismatch expected kind %0d code %0d start %0d len %0d err %0d last %0d",
                                 $time, t.kind, t.code, t.start, t.length, t.err, t.last);
                        $display("%t:          actual   kind %0d code %0d start %0d len %0d err %0d last %0d",
                                 $time, token_kind, token_code, token_start, token_length,
                                 error_code, last_of_run);
                    end
                end
            end
            if (in_valid && !in_stall) lex_item(char_code, end_of_stream);
        end
    end

endmodule

[verif/tb_c_subset_lexer_top.sv]
// Testbench top for the C subset lexer: drives source bytes and gives the verdict.
// Depends on c_subset_lexer_top, csl_pkg and the csl_checker module.
`timescale 1ns / 1ps

module tb_c_subset_lexer_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'd0;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  token_kind;
    logic [5:0]  token_code;
    logic [31:0] token_start;
    logic [11:0] token_length;
    logic [2:0]  error_code;
    logic        last_of_run;
    int          fail_count;
    int          tokens_due_count;
    int          bytes_sent = 0;
    int          cycles = 0;
    bit          gaps_on = 1'b1;

    string frags[] = '{"do", "for", "return", "break", "short", "else", "goto", "signed",
        "unsigned", "void", "char", "if", "int", "continue", "long", "while", "unsignedx",
        "whil", "continues", "<", ">", "=", "!", "%", "^", "&", "*", "-", "+", "~", "|",
        "/", "?", "+=", "-=", "*=", "/=", "%=", "&=", "^=", "|=", "++", "--", "<<", ">>",
        "<=", ">=", "==", "!=", "&&", "||", "<<=", ">>=", "(", ")", "[", "]", "{", "}",
        ",", ":", ";", "'\\''", "'\\'x", "'ab", "'\\", "\"", "'", "*/", "/**/"};
    localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string ESCS = "n'\"\\abftrv?qzx0";

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_stall <= gaps_on && ($urandom_range(99) < 16);
    end

    c_subset_lexer_top i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .end_of_stream(end_of_stream), .out_valid(out_valid),
        .out_stall(out_stall), .token_kind(token_kind), .token_code(token_code),
        .token_start(token_start), .token_length(token_length), .error_code(error_code),
        .last_of_run(last_of_run)
    );

    csl_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .end_of_stream(end_of_stream), .out_valid(out_valid),
        .out_stall(out_stall), .token_kind(token_kind), .token_code(token_code),
        .token_start(token_start), .token_length(token_length), .error_code(error_code),
        .last_of_run(last_of_run), .fail_count(fail_count),
        .tokens_due_count(tokens_due_count)
    );

    // Called right after a rising edge; returns right after the edge that took the item.
    task automatic send_item(input logic [7:0] b, input logic eos);
        logic held;
        while (gaps_on && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= b;
        end_of_stream <= eos;
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end
        while (held);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    function automatic string rand_piece();
        string s;
        int n;
        s = "";
        case ($urandom_range(9))
            0, 1: s = frags[$urandom_range(frags.size() - 1)];
            2:
            begin
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++)
                    s = {s, string'(LETTERS[$urandom_range(LETTERS.len() - 1)])};
                if ($urandom_range(1)) s = {s, "7"};
            end
            3:
            begin
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
            end
            4:
            begin
                s = "\"";
                n = $urandom_range(6);
                for (int i = 0; i < n; i++)
                    s = {s, string'(ESCS[$urandom_range(ESCS.len() - 1)])};
                s = {s, "\""};
            end
            5:
            begin
                // Octal escapes of one to three digits, eights and nines among them.
                s = "'\\";
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
                if ($urandom_range(5) != 0) s = {s, "'"};
            end
            6:
            begin
                s = {"'\\", string'(ESCS[$urandom_range(ESCS.len() - 1)]), "'"};
                if ($urandom_range(3) == 0) s = {"'", string'(LETTERS[$urandom_range(20)]), "'"};
            end
            7: s = {"/*", string'(LETTERS[$urandom_range(5)]), "**", "*/"};
            8: s = " ";
            default: s = "";
        endcase
        return s;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("int x<<=9;'\\8''\\''\"s\\\"\"'a");
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);

        while (bytes_sent < 550)
        begin
            gaps_on = !(bytes_sent > 250 && bytes_sent < 380);
            if ($urandom_range(11) == 0) send_item(8'($urandom_range(255)), 1'b0);
            else send_text(rand_piece());
            if ($urandom_range(3) == 0) send_text(" ");
            if ($urandom_range(29) == 0) send_item(8'($urandom_range(255)), 1'b1);
        end
        send_item(8'h00, 1'b1);
        in_valid <= 1'b0;
        gaps_on = 1'b1;

        while (tokens_due_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_c_subset_lexer_top: clean");
        else
            $display("tb_c_subset_lexer_top: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > 200000)
        begin
            $display("tb_c_subset_lexer_top: errors");
            $finish;
        end
    end

endmodule
